>>> hdl/mcfir_pkg.sv
// Package for the MIMO complex FIR channel core: shared types and constants.
// No dependencies.
package mcfir_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned OutW    = 40;

  localparam int unsigned MaxTx   = 4;
  localparam int unsigned MaxRx   = 4;
  localparam int unsigned MaxTaps = 64;

  localparam logic OpSample = 1'b0;
  localparam logic OpTap    = 1'b1;

  localparam logic [2:0] RegActiveTx  = 3'd0;
  localparam logic [2:0] RegActiveRx  = 3'd1;
  localparam logic [2:0] RegTapCount  = 3'd2;
  localparam logic [2:0] RegDbRxCount = 3'd3;
  localparam logic [2:0] RegTransp    = 3'd4;

  // request passed from front to back through the queue
  typedef struct packed {
    logic [5:0] hptr;
  } job_t;

endpackage

>>> hdl/mcfir_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module mcfir_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> hdl/mcfir_front.sv
// Front part: accepts requests, writes taps and samples, queues instants.
// Depends on mcfir_pkg.
module mcfir_front
  import mcfir_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [1:0]  antenna_i,
  input  logic [31:0] sample_i,
  input  logic [3:0]  tap_link_i,
  input  logic [5:0]  tap_index_i,
  input  logic [31:0] coef_i,
  input  logic [2:0]  ntx_i,
  input  logic        clear_done_i,
  output logic        tap_we_o,
  output logic [9:0]  tap_waddr_o,
  output logic [31:0] tap_wdata_o,
  output logic        hist_we_o,
  output logic [7:0]  hist_waddr_o,
  output logic [31:0] hist_wdata_o,
  output logic        job_valid_o,
  input  logic        job_ready_i,
  output job_t        job_o
);
  logic [5:0] hptr_q, hptr_d;
  logic       full_q;
  job_t       job_q;
  logic       acc, is_last, tx_ok;

  // hold off requests while the history clear runs, an instant is queued or the back end is busy
  assign tx_ok      = {1'b0, antenna_i} < ntx_i;
  assign is_last    = {1'b0, antenna_i} == ntx_i - 3'd1;
  assign in_ready_o = clear_done_i && !full_q && job_ready_i;
  assign acc        = in_valid_i && in_ready_o;

  assign tap_we_o     = acc && opcode_i == OpTap;
  assign tap_waddr_o  = {tap_link_i, tap_index_i};
  assign tap_wdata_o  = coef_i;
  assign hist_we_o    = acc && opcode_i == OpSample && tx_ok;
  assign hist_waddr_o = {antenna_i, hptr_q};
  assign hist_wdata_o = sample_i;

  assign job_valid_o = full_q;
  assign job_o       = job_q;

  always_comb begin
    hptr_d = hptr_q;
    if (hist_we_o && is_last) begin
      hptr_d = hptr_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hptr_q <= '0;
      full_q <= 1'b0;
    end else begin
      hptr_q <= hptr_d;
      if (hist_we_o && is_last) begin
        full_q <= 1'b1;
      end else if (job_ready_i) begin
        full_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_we_o && is_last) begin
      job_q <= '{hptr: hptr_q};
    end
  end

  a_job_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q && !job_ready_i |=> full_q && $stable(job_q)) else $error("job lost");
  a_no_acc_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> !acc) else $error("accept while queue full");
  a_ptr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(hist_we_o && is_last) |=> $stable(hptr_q)) else $error("pointer moved");
endmodule

>>> hdl/mcfir_back.sv
// Back part: walks rx, tx and taps with one complex MAC, emits results.
// Depends on mcfir_pkg.
module mcfir_back
  import mcfir_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [2:0]  ntx_i,
  input  logic [2:0]  nrx_i,
  input  logic [6:0]  ntap_i,
  input  logic [2:0]  stride_i,
  input  logic        transposed_i,
  input  logic        job_valid_i,
  output logic        job_ready_o,
  input  job_t        job_i,
  output logic [9:0]  tap_raddr_o,
  input  logic [31:0] tap_rdata_i,
  output logic [7:0]  hist_raddr_o,
  input  logic [31:0] hist_rdata_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  rx_index_o,
  output logic [39:0] out_re_o,
  output logic [39:0] out_im_o,
  output logic        last_o
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRun  = 3'd1;
  localparam logic [2:0] StDrain = 3'd2;
  localparam logic [2:0] StOut  = 3'd3;

  logic [2:0] st_q;
  logic [5:0] hptr_q;
  logic [1:0] r_q, t_q;
  logic [5:0] l_q;
  logic       v1_q, v2_q;
  logic       v3_q;
  logic [31:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic [41:0] acc_re_q, acc_im_q;
  logic [3:0]  link_full;
  logic        step_last;
  logic        issue;

  always_comb begin
    if (transposed_i) link_full = 4'(r_q * stride_i) + 4'(t_q);
    else              link_full = 4'(r_q) + 4'(t_q * stride_i);
  end
  assign tap_raddr_o  = {link_full, l_q};
  assign hist_raddr_o = {t_q, hptr_q - l_q};
  assign issue        = st_q == StRun;
  assign step_last    = {1'b0, l_q} == ntap_i - 7'd1 && {1'b0, t_q} == ntx_i - 3'd1;
  assign job_ready_o  = st_q == StIdle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      out_valid_o <= 1'b0;
      r_q <= '0; t_q <= '0; l_q <= '0; hptr_q <= '0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      unique case (st_q)
        StIdle: if (job_valid_i) begin
          hptr_q <= job_i.hptr;
          r_q <= '0; t_q <= '0; l_q <= '0;
          st_q <= StRun;
        end
        StRun: begin
          if (step_last) begin
            st_q <= StDrain;
          end else if ({1'b0, l_q} == ntap_i - 7'd1) begin
            l_q <= '0;
            t_q <= t_q + 2'd1;
          end else begin
            l_q <= l_q + 6'd1;
          end
        end
        StDrain: if (!v1_q && !v2_q && !v3_q) begin
          out_valid_o <= 1'b1;
          st_q <= StOut;
        end
        StOut: if (out_ready_i) begin
          out_valid_o <= 1'b0;
          if ({1'b0, r_q} == nrx_i - 3'd1) begin
            st_q <= StIdle;
          end else begin
            r_q <= r_q + 2'd1;
            t_q <= '0; l_q <= '0;
            st_q <= StRun;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  // stage 2: products; stage 3: accumulate
  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      p_rr_q <= $signed(tap_rdata_i[15:0])  * $signed(hist_rdata_i[15:0]);
      p_ii_q <= $signed(tap_rdata_i[31:16]) * $signed(hist_rdata_i[31:16]);
      p_ri_q <= $signed(tap_rdata_i[15:0])  * $signed(hist_rdata_i[31:16]);
      p_ir_q <= $signed(tap_rdata_i[31:16]) * $signed(hist_rdata_i[15:0]);
    end
    if (st_q == StIdle || (st_q == StOut && out_ready_i)) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (v2_q) begin
      acc_re_q <= acc_re_q + 42'($signed(p_rr_q)) - 42'($signed(p_ii_q));
      acc_im_q <= acc_im_q + 42'($signed(p_ri_q)) + 42'($signed(p_ir_q));
    end
  end

  function automatic logic [39:0] sat40(logic [41:0] v);
    if (v[41:39] == 3'b000 || v[41:39] == 3'b111) return v[39:0];
    return v[41] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
  endfunction

  assign rx_index_o = r_q;
  assign out_re_o   = sat40(acc_re_q);
  assign out_im_o   = sat40(acc_im_q);
  assign last_o     = {1'b0, r_q} == nrx_i - 3'd1;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_re_o))
    else $error("result dropped");
  a_no_mac_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !v2_q) else $error("mac during output");
endmodule

>>> hdl/mimo_complex_fir_channel_core.sv
// MIMO complex FIR channel core. Tap writes and non-final samples give no result.
// The last active antenna sample queues an instant for the back end, which then for
// each rx antenna walks active_tx*tap_count products on a single MAC, drains the
// pipeline and outputs one result. Input is held off until the last result leaves.
// After reset a pass over all 256 entries clears the sample history; no input taken.
// Depends on mcfir_pkg, mcfir_ram, mcfir_front, mcfir_back.
module mimo_complex_fir_channel_core
  import mcfir_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode
  input  logic        s_axis_tuser,
  // antenna, sample_re, sample_im, tap_link, tap_index, coef_re, coef_im
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // rx_index, out_re, out_im
  output logic [87:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [6:0]  cfg_data_i
);
  logic [2:0] atx_q, arx_q, dbr_q;
  logic [6:0] tcnt_q;
  logic       tr_q;
  logic [2:0] ntx, nrx, stride, mtx, mrx;
  logic [6:0] ntap, mtap;
  logic [8:0] clr_q;
  logic       clr_done;

  assign mtx  = 3'(MaxTx);
  assign mrx  = 3'(MaxRx);
  assign mtap = 7'(MaxTaps);
  assign ntx    = atx_q == 0 ? 3'd1 : (atx_q > mtx ? mtx : atx_q);
  assign nrx    = arx_q == 0 ? 3'd1 : (arx_q > mrx ? mrx : arx_q);
  assign stride = dbr_q == 0 ? 3'd1 : (dbr_q > mrx ? mrx : dbr_q);
  assign ntap   = tcnt_q == 0 ? 7'd1 : (tcnt_q > mtap ? mtap : tcnt_q);
  assign clr_done = clr_q[8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atx_q <= 3'd1; arx_q <= 3'd1; tcnt_q <= 7'd1; dbr_q <= 3'd1; tr_q <= 1'b0;
      clr_q <= '0;
    end else begin
      if (!clr_done) clr_q <= clr_q + 9'd1;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegActiveTx:  atx_q  <= cfg_data_i[2:0];
          RegActiveRx:  arx_q  <= cfg_data_i[2:0];
          RegTapCount:  tcnt_q <= cfg_data_i;
          RegDbRxCount: dbr_q  <= cfg_data_i[2:0];
          RegTransp:    tr_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  logic        tap_we, hist_we, f_hist_we, job_valid, job_ready;
  logic [9:0]  tap_waddr, tap_raddr;
  logic [7:0]  hist_waddr, f_hist_waddr, hist_raddr;
  logic [31:0] tap_wdata, hist_wdata, f_hist_wdata, tap_rdata, hist_rdata;
  job_t        job;
  logic [1:0]  rx_index;
  logic [39:0] out_re, out_im;

  assign hist_we    = f_hist_we || !clr_done;
  assign hist_waddr = clr_done ? f_hist_waddr : clr_q[7:0];
  assign hist_wdata = clr_done ? f_hist_wdata : 32'd0;

  mcfir_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .opcode_i(s_axis_tuser), .antenna_i(s_axis_tdata[1:0]),
    .sample_i(s_axis_tdata[33:2]), .tap_link_i(s_axis_tdata[37:34]),
    .tap_index_i(s_axis_tdata[43:38]), .coef_i(s_axis_tdata[75:44]),
    .ntx_i(ntx), .clear_done_i(clr_done),
    .tap_we_o(tap_we), .tap_waddr_o(tap_waddr), .tap_wdata_o(tap_wdata),
    .hist_we_o(f_hist_we), .hist_waddr_o(f_hist_waddr), .hist_wdata_o(f_hist_wdata),
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  mcfir_ram #(.Width(32), .Depth(1024)) u_taps (
    .clk_i, .we_i(tap_we), .waddr_i(tap_waddr), .wdata_i(tap_wdata),
    .raddr_i(tap_raddr), .rdata_o(tap_rdata)
  );

  mcfir_ram #(.Width(32), .Depth(256)) u_hist (
    .clk_i, .we_i(hist_we), .waddr_i(hist_waddr), .wdata_i(hist_wdata),
    .raddr_i(hist_raddr), .rdata_o(hist_rdata)
  );

  mcfir_back u_back (
    .clk_i, .rst_ni,
    .ntx_i(ntx), .nrx_i(nrx), .ntap_i(ntap), .stride_i(stride), .transposed_i(tr_q),
    .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .tap_raddr_o(tap_raddr), .tap_rdata_i(tap_rdata),
    .hist_raddr_o(hist_raddr), .hist_rdata_i(hist_rdata),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .rx_index_o(rx_index), .out_re_o(out_re), .out_im_o(out_im), .last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, out_im, out_re, rx_index};
endmodule

>>> dv/mcfir_checker.sv
// Checker for the MIMO complex FIR channel core: mirrors tap store, sample history
// and registers from the observed requests, predicts every receive sum and compares.
// Depends on mcfir_pkg.
`timescale 1ns / 100ps
module mcfir_checker
  import mcfir_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic         s_axis_tuser,
  input  logic [79:0]  s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [87:0]  m_axis_tdata,
  input  logic         m_axis_tlast,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [6:0]   cfg_data_i,
  output int           fail_cnt_o,
  output int           pending_o
);
  localparam int NTX = 4, NRX = 4, NTAPS = 64, NLINKS = 16;
  localparam longint SumMax = 64'sd549755813887;
  localparam longint SumMin = -64'sd549755813888;

  typedef struct {
    logic [1:0]         rx;
    logic signed [39:0] re;
    logic signed [39:0] im;
    logic               last;
  } rx_sum_t;

  rx_sum_t rx_sums_q[$];
  logic [2:0] act_tx, act_rx, db_rx;
  logic [6:0] taps;
  logic       transp;
  logic signed [15:0] hist_re[NTX][NTAPS], hist_im[NTX][NTAPS];
  logic signed [15:0] coef_re[NLINKS][NTAPS], coef_im[NLINKS][NTAPS];
  logic [5:0] hptr;
  int fails;

  assign fail_cnt_o = fails;
  assign pending_o  = rx_sums_q.size();

  function automatic int eff(int v, int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic logic signed [39:0] sat40(longint v);
    if (v > SumMax) v = SumMax;
    if (v < SumMin) v = SumMin;
    return v[39:0];
  endfunction

  task automatic predict_instant();
    int nt, nr, nl, stride, lk, pos;
    longint are, aim, hr, hi, xr, xi;
    rx_sum_t e;
    nt = eff(act_tx, NTX);
    nr = eff(act_rx, NRX);
    nl = eff(taps, NTAPS);
    stride = eff(db_rx, NRX);
    for (int r = 0; r < nr; r++) begin
      are = 0;
      aim = 0;
      for (int t = 0; t < nt; t++) begin
        lk = (transp ? (r * stride + t) : (r + t * stride)) % NLINKS;
        for (int l = 0; l < nl; l++) begin
          pos = (hptr + NTAPS - l) % NTAPS;
          hr = coef_re[lk][l];
          hi = coef_im[lk][l];
          xr = hist_re[t][pos];
          xi = hist_im[t][pos];
          are += hr * xr - hi * xi;
          aim += hr * xi + hi * xr;
        end
      end
      e.rx = r[1:0];
      e.re = sat40(are);
      e.im = sat40(aim);
      e.last = (r == nr - 1);
      rx_sums_q.push_back(e);
    end
    hptr <= hptr + 6'd1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rx_sum_t e;
    logic [1:0] ant;
    if (!rst_ni) begin
      act_tx <= 3'd1;
      act_rx <= 3'd1;
      taps <= 7'd1;
      db_rx <= 3'd1;
      transp <= 1'b0;
      hptr <= '0;
      fails = 0;
      rx_sums_q.delete();
      for (int t = 0; t < NTX; t++)
        for (int l = 0; l < NTAPS; l++) begin
          hist_re[t][l] = '0;
          hist_im[t][l] = '0;
        end
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (rx_sums_q.size() == 0) begin
          $error("unexpected result rx_index=%0d", m_axis_tdata[1:0]);
          fails++;
        end else begin
          e = rx_sums_q.pop_front();
          if (m_axis_tdata[1:0] !== e.rx) begin
            $error("rx_index: expected %0d, got %0d", e.rx, m_axis_tdata[1:0]);
            fails++;
          end
          if (m_axis_tdata[41:2] !== e.re) begin
            $error("out_re: expected %0d, got %0d", e.re, $signed(m_axis_tdata[41:2]));
            fails++;
          end
          if (m_axis_tdata[81:42] !== e.im) begin
            $error("out_im: expected %0d, got %0d", e.im, $signed(m_axis_tdata[81:42]));
            fails++;
          end
          if (m_axis_tlast !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, m_axis_tlast);
            fails++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegActiveTx:  act_tx <= cfg_data_i[2:0];
          RegActiveRx:  act_rx <= cfg_data_i[2:0];
          RegTapCount:  taps <= cfg_data_i;
          RegDbRxCount: db_rx <= cfg_data_i[2:0];
          RegTransp:    transp <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == OpTap) begin
          coef_re[s_axis_tdata[37:34]][s_axis_tdata[43:38]] = s_axis_tdata[59:44];
          coef_im[s_axis_tdata[37:34]][s_axis_tdata[43:38]] = s_axis_tdata[75:60];
        end else begin
          ant = s_axis_tdata[1:0];
          if (ant < eff(act_tx, NTX)) begin
            hist_re[ant][hptr] = s_axis_tdata[17:2];
            hist_im[ant][hptr] = s_axis_tdata[33:18];
            if (ant == eff(act_tx, NTX) - 1) predict_instant();
          end
        end
      end
    end
  end
endmodule

>>> dv/tb.sv
// Top of the MIMO complex FIR channel core testbench: clock, reset, request
// stimulus, receive stalls and verdict. Depends on mcfir_pkg, mcfir_checker and the core.
`timescale 1ns / 100ps
module tb;
  import mcfir_pkg::*;

  localparam logic [2:0] RegUnused = 3'd7;
  localparam int SettleCycles = 1200;
  localparam int LimitCycles = 2000000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic         s_axis_tuser = 1'b0;
  logic [79:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [87:0]  m_axis_tdata;
  logic         m_axis_tlast;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [6:0]   cfg_data_i = '0;
  int fail_cnt, pending, burst_left, cur_tx;
  int cycles = 0;
  int stall_mode = 0;
  logic req_taken;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  mimo_complex_fir_channel_core dut (.*);

  mcfir_checker chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  always @(posedge clk_i) req_taken <= s_axis_tvalid & s_axis_tready;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if ($urandom_range(0, 299) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic logic [15:0] rnd16();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send(logic op, logic [79:0] d);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= d;
    do @(negedge clk_i); while (!req_taken);
  endtask

  task automatic push(logic [1:0] ant, logic [15:0] re, logic [15:0] im);
    send(OpSample, {4'd0, 42'd0, im, re, ant});
  endtask

  task automatic tap(logic [3:0] lk, logic [5:0] ix, logic [15:0] re, logic [15:0] im);
    send(OpTap, {4'd0, im, re, ix, lk, 34'd0});
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic cfg(logic [2:0] idx, logic [6:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic phase(int tx, int rx, int tc, int db, int tr, int n);
    int cnt;
    settle();
    cfg(RegActiveTx, 7'(tx));
    cfg(RegActiveRx, 7'(rx));
    cfg(RegTapCount, 7'(tc));
    cfg(RegDbRxCount, 7'(db));
    cfg(RegTransp, 7'(tr));
    cur_tx = (tx == 0) ? 1 : (tx > 4 ? 4 : tx);
    cnt = 0;
    while (cnt < n) begin
      case ($urandom_range(0, 9))
        7: begin
          tap(4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)), rnd16(), rnd16());
          cnt++;
        end
        8: if (cur_tx < 4) push(2'($urandom_range(cur_tx, 3)), rnd16(), rnd16());
        9: begin
          push(2'($urandom_range(0, cur_tx - 1)), rnd16(), rnd16());
          cnt++;
        end
        default:
          for (int a = 0; a < cur_tx; a++) begin
            push(2'(a), rnd16(), rnd16());
            cnt++;
          end
      endcase
    end
  endtask

  initial begin
    burst_left = 0;
    cur_tx = 1;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (300) @(negedge clk_i);
    // link 0 gets the full response, the other links the first eight taps
    for (int l = 0; l < 16; l++)
      for (int i = 0; i < ((l == 0) ? 64 : 8); i++)
        tap(4'(l), 6'(i), 16'($urandom), 16'($urandom));
    // defaults: one tx, one rx, one tap
    tap(0, 0, 16'h8000, 16'h8000);
    push(0, 16'h8000, 16'h8000);
    push(0, 16'h7fff, 16'h8000);
    tap(0, 0, 16'h7fff, 16'h7fff);
    push(0, 16'h7fff, 16'h7fff);
    push(0, 16'h8000, 16'h7fff);
    push(0, 16'h0000, 16'hffff);
    push(3, 16'h1234, 16'h5678);
    push(1, 16'h7fff, 16'h7fff);
    tap(15, 63, 16'h7fff, 16'h8000);
    tap(0, 0, 16'h0001, 16'hffff);
    push(0, 16'h0001, 16'h0000);
    settle();
    cfg(RegUnused, 7'h7f);
    phase(0, 0, 0, 0, 0, 20);
    phase(1, 1, 64, 4, 1, 30);
    phase(1, 0, 127, 0, 0, 30);
    phase(7, 7, 3, 7, 0, 40);
    phase(2, 3, 5, 2, 1, 40);
    phase(3, 4, 8, 3, 0, 40);
    phase(3, 2, 8, 1, 1, 40);
    phase(1, 4, 2, 3, 1, 30);
    settle();
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
